// ===== hw/rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg - proxy protocol sniffer package
// Class codes, byte constants, HTTP method table and shared types.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int unsigned POS_W       = 6;
    localparam int unsigned NUM_METHODS = 9;
    localparam int unsigned METHOD_MAX  = 8;

    localparam logic [POS_W-1:0] POS_LIMIT = 6'd60;
    localparam logic [POS_W-1:0] VLESS_MIN = 6'd22;
    localparam logic [POS_W-1:0] HEX_RUN   = 6'd56;

    localparam logic [POS_W-1:0] POS_TLS_VER  = 6'd1;
    localparam logic [POS_W-1:0] POS_VL_A     = 6'd17;
    localparam logic [POS_W-1:0] POS_VL_CMD   = 6'd18;
    localparam logic [POS_W-1:0] POS_VL_ATYP  = 6'd21;
    localparam logic [POS_W-1:0] POS_TJ_CR    = 6'd56;
    localparam logic [POS_W-1:0] POS_TJ_LF    = 6'd57;
    localparam logic [POS_W-1:0] POS_TJ_CMD   = 6'd58;
    localparam logic [POS_W-1:0] POS_TJ_ATYP  = 6'd59;

    localparam logic [7:0] BYTE_SOCKS5  = 8'h05;
    localparam logic [7:0] BYTE_TLS_REC = 8'h16;
    localparam logic [7:0] BYTE_TLS_VER = 8'h03;
    localparam logic [7:0] BYTE_CR      = 8'h0D;
    localparam logic [7:0] BYTE_LF      = 8'h0A;
    localparam logic [7:0] BYTE_01      = 8'h01;
    localparam logic [7:0] BYTE_02      = 8'h02;
    localparam logic [7:0] BYTE_03      = 8'h03;
    localparam logic [7:0] BYTE_04      = 8'h04;
    localparam logic [7:0] BYTE_7F      = 8'h7F;
    localparam logic [7:0] BYTE_00      = 8'h00;

    typedef enum logic [2:0] {
        CLS_UNKNOWN     = 3'd0,
        CLS_SOCKS5      = 3'd1,
        CLS_TLS         = 3'd2,
        CLS_HTTP        = 3'd3,
        CLS_VLESS       = 3'd4,
        CLS_TROJAN      = 3'd5,
        CLS_SHADOWSOCKS = 3'd6
    } class_t;

    typedef struct packed {
        logic   valid;
        class_t cls;
    } res_t;

    // GET POST HEAD PUT DELETE CONNECT OPTIONS TRACE PATCH, each with a space
    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
        4'd4, 4'd5, 4'd5, 4'd4, 4'd7, 4'd8, 4'd8, 4'd6, 4'd6
    };

    localparam logic [7:0] METHOD_TXT [NUM_METHODS][METHOD_MAX] = '{
        '{"G", "E", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", " ", 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", " ", 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", " ", 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T", " "},
        '{"O", "P", "T", "I", "O", "N", "S", " "},
        '{"T", "R", "A", "C", "E", " ", 8'h00, 8'h00},
        '{"P", "A", "T", "C", "H", " ", 8'h00, 8'h00}
    };

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "f"))
            || ((c >= "A") && (c <= "F"));
        return r;
    endfunction

endpackage

// ===== hw/rtl/pps_ifs.sv =====
// ----------------------------------------------------------------------------
// pps_ifs - sniffer channel interfaces
// Byte input, class result and mode write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty_peek;

    modport source (output valid, output data_byte, output last_byte,
                    output empty_peek, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input empty_peek, output ready);
endinterface

interface pps_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] protocol_class;

    modport source (output valid, output protocol_class, input ready);
    modport sink   (input valid, input protocol_class, output ready);
endinterface

interface pps_cfg_if;
    logic valid;
    logic ready;
    logic sniff_mode;

    modport source (output valid, output sniff_mode, input ready);
    modport sink   (input valid, input sniff_mode, output ready);
endinterface

// ===== hw/rtl/proxy_protocol_sniffer.sv =====
// ----------------------------------------------------------------------------
// proxy_protocol_sniffer - connection opening classifier
// Takes peeked bytes one beat at a time and returns a protocol class on
// the marked or empty-peek beat.
// ----------------------------------------------------------------------------
// The class for a marked or empty-peek beat is registered in pps_res_buf.
// Throughput: one byte beat per cycle; flags update in a single pass.
// Input stalls only while both result entries (output and skid) are full.
// Reset: asynchronous, clears flags, mode to outer and result buffer.
module proxy_protocol_sniffer
(
    input logic       clk,
    input logic       rst_n,
    pps_in_if.sink    in_ch,
    pps_out_if.source out_ch,
    pps_cfg_if.sink   cfg
);
    import pps_pkg::*;

    logic mode_reg, mode_next;
    logic accept, space;
    res_t res;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;
    assign mode_next   = (cfg.valid) ? cfg.sniff_mode : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else
            mode_reg <= mode_next;
    end

    pps_track u_track
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (in_ch.data_byte),
        .last_byte  (in_ch.last_byte),
        .empty_peek (in_ch.empty_peek),
        .sniff_mode (mode_reg),
        .res        (res)
    );

    pps_res_buf u_res_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res),
        .space     (space),
        .out_valid (out_ch.valid),
        .out_class (out_ch.protocol_class),
        .out_ready (out_ch.ready)
    );

endmodule

// ===== hw/rtl/pps_track.sv =====
// ----------------------------------------------------------------------------
// pps_track - running byte flags and classifier
// Updates the per-connection flags on each accepted beat and classifies
// on the marked or empty-peek beat; flags are cleared after every result.
// ----------------------------------------------------------------------------
module pps_track
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     data_byte,
    input  logic           last_byte,
    input  logic           empty_peek,
    input  logic           sniff_mode,
    output pps_pkg::res_t  res
);
    import pps_pkg::*;

    logic [POS_W-1:0]       pos_reg, pos_next, pos_up;
    logic [7:0]             open_reg, open_next, open_up;
    logic                   tls_reg, tls_next, tls_up;
    logic [NUM_METHODS-1:0] meth_reg, meth_next, meth_up, meth_reach;
    logic                   vless_reg, vless_next, vless_up;
    logic                   hex_reg, hex_next, hex_up;
    logic                   tail_reg, tail_next, tail_up;
    logic                   take, http_hit;
    logic                   vl_cmd_ok, vl_atyp_ok, tj_cmd_ok, tj_atyp_ok;
    class_t                 cls;

    assign take = (pos_reg < POS_LIMIT);

    assign vl_cmd_ok  = (data_byte == BYTE_01) || (data_byte == BYTE_02)
                        || (data_byte == BYTE_7F);
    assign vl_atyp_ok = (data_byte == BYTE_01) || (data_byte == BYTE_02)
                        || (data_byte == BYTE_03);
    assign tj_cmd_ok  = (data_byte == BYTE_01) || (data_byte == BYTE_03)
                        || (data_byte == BYTE_7F);
    assign tj_atyp_ok = (data_byte == BYTE_01) || (data_byte == BYTE_03)
                        || (data_byte == BYTE_04);

    always_comb
    begin
        pos_up  = take ? pos_reg + 1'b1 : pos_reg;
        open_up = (take && (pos_reg == '0)) ? data_byte : open_reg;
        tls_up  = tls_reg | (take && (pos_reg == POS_TLS_VER)
                             && (data_byte == BYTE_TLS_VER));

        for (int m = 0; m < NUM_METHODS; m++)
        begin
            meth_up[m] = meth_reg[m]
                & !(take && (pos_reg < {2'b00, METHOD_LEN[m]})
                    && (data_byte != METHOD_TXT[m][pos_reg[2:0]]));
            meth_reach[m] = (pos_up >= {2'b00, METHOD_LEN[m]});
        end
        http_hit = |(meth_up & meth_reach);

        vless_up = vless_reg;
        if (take)
        begin
            if ((pos_reg == '0) && (data_byte != BYTE_00))
                vless_up = 1'b0;
            if ((pos_reg == POS_VL_A) && (data_byte != BYTE_00))
                vless_up = 1'b0;
            if ((pos_reg == POS_VL_CMD) && !vl_cmd_ok)
                vless_up = 1'b0;
            if ((pos_reg == POS_VL_ATYP) && !vl_atyp_ok)
                vless_up = 1'b0;
        end

        hex_up = hex_reg & !(take && (pos_reg < HEX_RUN) && !is_hex(data_byte));

        tail_up = tail_reg;
        if (take)
        begin
            if ((pos_reg == POS_TJ_CR) && (data_byte != BYTE_CR))
                tail_up = 1'b0;
            if ((pos_reg == POS_TJ_LF) && (data_byte != BYTE_LF))
                tail_up = 1'b0;
            if ((pos_reg == POS_TJ_CMD) && !tj_cmd_ok)
                tail_up = 1'b0;
            if ((pos_reg == POS_TJ_ATYP) && !tj_atyp_ok)
                tail_up = 1'b0;
        end

        // classify from the flags after this beat
        if (empty_peek)
        begin
            if (sniff_mode)
                cls = CLS_SHADOWSOCKS;
            else
                cls = CLS_UNKNOWN;
        end
        else if (!sniff_mode)
        begin
            priority if ((pos_up != '0) && (open_up == BYTE_SOCKS5))
                cls = CLS_SOCKS5;
            else if ((pos_up >= 6'd2) && (open_up == BYTE_TLS_REC) && tls_up)
                cls = CLS_TLS;
            else if (http_hit)
                cls = CLS_HTTP;
            else
                cls = CLS_SHADOWSOCKS;
        end
        else
        begin
            priority if (http_hit)
                cls = CLS_HTTP;
            else if ((pos_up >= VLESS_MIN) && vless_up)
                cls = CLS_VLESS;
            else if ((pos_up >= POS_LIMIT) && hex_up && tail_up)
                cls = CLS_TROJAN;
            else
                cls = CLS_SHADOWSOCKS;
        end

        res.valid = accept && (empty_peek || last_byte);
        res.cls   = cls;

        pos_next   = pos_reg;
        open_next  = open_reg;
        tls_next   = tls_reg;
        meth_next  = meth_reg;
        vless_next = vless_reg;
        hex_next   = hex_reg;
        tail_next  = tail_reg;
        if (accept)
        begin
            if (empty_peek || last_byte)
            begin
                pos_next   = '0;
                open_next  = '0;
                tls_next   = 1'b0;
                meth_next  = '1;
                vless_next = 1'b1;
                hex_next   = 1'b1;
                tail_next  = 1'b1;
            end
            else
            begin
                pos_next   = pos_up;
                open_next  = open_up;
                tls_next   = tls_up;
                meth_next  = meth_up;
                vless_next = vless_up;
                hex_next   = hex_up;
                tail_next  = tail_up;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            open_reg  <= '0;
            tls_reg   <= 1'b0;
            meth_reg  <= '1;
            vless_reg <= 1'b1;
            hex_reg   <= 1'b1;
            tail_reg  <= 1'b1;
        end
        else
        begin
            pos_reg   <= pos_next;
            open_reg  <= open_next;
            tls_reg   <= tls_next;
            meth_reg  <= meth_next;
            vless_reg <= vless_next;
            hex_reg   <= hex_next;
            tail_reg  <= tail_next;
        end
    end

endmodule

// ===== hw/rtl/pps_res_buf.sv =====
// ----------------------------------------------------------------------------
// pps_res_buf - result register with skid stage
// Two-entry result buffer; input side stalls only when the skid entry is full.
// ----------------------------------------------------------------------------
module pps_res_buf
(
    input  logic          clk,
    input  logic          rst_n,
    input  pps_pkg::res_t push,
    output logic          space,
    output logic          out_valid,
    output logic [2:0]    out_class,
    input  logic          out_ready
);
    import pps_pkg::*;

    logic   main_valid_reg, main_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    class_t main_reg, main_next;
    class_t skid_reg, skid_next;
    logic   pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_class = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push.valid)
                main_next = push.cls;
            else
                main_valid_next = 1'b0;
        end
        else if (push.valid)
        begin
            if (!main_valid_reg)
            begin
                main_next       = push.cls;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push.cls;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== hw/rtl/pps_checker.sv =====
// ----------------------------------------------------------------------------
// pps_checker - port-level checks for the sniffer
// Watches the input and result channels; bound to proxy_protocol_sniffer.
// ----------------------------------------------------------------------------
module pps_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       last_byte,
    input logic       empty_peek,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] protocol_class
);
    import pps_pkg::*;

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // a marked beat into an empty buffer shows a result next cycle
    a_res_appears: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (last_byte || empty_peek) && !out_valid |=> out_valid)
        else $error("result missing after marked beat");

    // an unmarked beat into an empty buffer gives no result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !last_byte && !empty_peek && !out_valid |=> !out_valid)
        else $error("result without a marked beat");

    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (protocol_class != 3'd7))
        else $error("class code out of range");

endmodule

bind proxy_protocol_sniffer pps_checker u_pps_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .last_byte      (in_ch.last_byte),
    .empty_peek     (in_ch.empty_peek),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .protocol_class (out_ch.protocol_class)
);
